@@ rtl/rsi_pkg.sv @@
// ----------------------------------------------------------------------------
// rsi_pkg
// Widths, constants and item types shared by the ray/sphere intersection unit.
// ----------------------------------------------------------------------------
package rsi_pkg;

	localparam int COORD_FRAC_BITS = 16;

	localparam int CRD_W  = 32;
	localparam int RAD_W  = 31;
	localparam int DIF_W  = CRD_W + 1;
	localparam int PRD_W  = 2 * DIF_W;
	localparam int RSQ_W  = 2 * RAD_W;
	localparam int A_W    = PRD_W + 2;
	localparam int H_W    = A_W + 1;
	localparam int HALF_W = A_W / 2;
	localparam int PP_W   = 2 * HALF_W;
	localparam int SQ_W   = 2 * A_W;
	localparam int XS_W   = SQ_W + 1;
	localparam int X_W    = A_W + RSQ_W;
	localparam int RD_W   = X_W + 2 * COORD_FRAC_BITS;
	localparam int S_W    = RD_W / 2;
	localparam int RM_W   = S_W + 2;
	localparam int N_W    = ((H_W + COORD_FRAC_BITS) > S_W ? H_W + COORD_FRAC_BITS : S_W) + 2;
	localparam int Q_W    = 32;
	localparam int DV_W   = ((N_W > A_W + Q_W) ? N_W : A_W + Q_W) + 1;
	localparam int QUE_D  = 4;
	localparam int QUE_PW = 2;

	localparam logic [Q_W-1:0] DIST_MIN = {1'b1, {(Q_W-1){1'b0}}};
	localparam logic [Q_W-1:0] DIST_MAX = {1'b0, {(Q_W-1){1'b1}}};

	typedef struct packed {
		logic           miss;
		logic [A_W-1:0] a;
		logic [H_W-1:0] h;
	} rsi_tag_t;

	typedef struct packed {
		rsi_tag_t       tag;
		logic [X_W-1:0] x;
	} rsi_job_t;

endpackage

@@ rtl/rsi_front.sv @@
// ----------------------------------------------------------------------------
// rsi_front
// Accepts items, forms a, h, c and the discriminant, classifies hit or miss.
// ----------------------------------------------------------------------------
module rsi_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [rsi_pkg::CRD_W-1:0]  center_x,
	input  logic signed [rsi_pkg::CRD_W-1:0]  center_y,
	input  logic signed [rsi_pkg::CRD_W-1:0]  center_z,
	input  logic        [rsi_pkg::RAD_W-1:0]  sphere_radius,
	input  logic signed [rsi_pkg::CRD_W-1:0]  ray_start_x,
	input  logic signed [rsi_pkg::CRD_W-1:0]  ray_start_y,
	input  logic signed [rsi_pkg::CRD_W-1:0]  ray_start_z,
	input  logic signed [rsi_pkg::CRD_W-1:0]  ray_end_x,
	input  logic signed [rsi_pkg::CRD_W-1:0]  ray_end_y,
	input  logic signed [rsi_pkg::CRD_W-1:0]  ray_end_z,
	input  logic                              q_full,
	output logic                              push,
	output rsi_pkg::rsi_job_t                 push_job
);
	import rsi_pkg::*;

	logic [6:0] fv_q;
	logic       adv;

	logic signed [CRD_W-1:0] cen [3];
	logic signed [CRD_W-1:0] st  [3];
	logic signed [CRD_W-1:0] fin [3];

	logic signed [DIF_W-1:0] d_s1  [3];
	logic signed [DIF_W-1:0] oc_s1 [3];
	logic        [RAD_W-1:0] r_s1;

	logic signed [PRD_W-1:0] dd_s2 [3];
	logic signed [PRD_W-1:0] od_s2 [3];
	logic signed [PRD_W-1:0] oo_s2 [3];
	logic        [RSQ_W-1:0] rr_s2;

	logic        [A_W-1:0] a_s3;
	logic signed [H_W-1:0] h_s3;
	logic signed [H_W-1:0] c_s3;

	logic [A_W-1:0] a_s4;
	logic [A_W-1:0] hm_s4;
	logic [A_W-1:0] cm_s4;
	logic [H_W-1:0] h_s4;
	logic           cn_s4;

	logic [A_W-1:0]  a_s5;
	logic [H_W-1:0]  h_s5;
	logic            cn_s5;
	logic [PP_W-1:0] hll_s5, hlh_s5, hhh_s5;
	logic [PP_W-1:0] all_s5, alh_s5, ahl_s5, ahh_s5;

	logic [A_W-1:0]  a_s6;
	logic [H_W-1:0]  h_s6;
	logic            cn_s6;
	logic [SQ_W-1:0] h2_s6;
	logic [SQ_W-1:0] ac_s6;

	logic [XS_W-1:0] xs;
	rsi_job_t        job_s7;

	assign cen[0] = center_x;
	assign cen[1] = center_y;
	assign cen[2] = center_z;
	assign st[0]  = ray_start_x;
	assign st[1]  = ray_start_y;
	assign st[2]  = ray_start_z;
	assign fin[0] = ray_end_x;
	assign fin[1] = ray_end_y;
	assign fin[2] = ray_end_z;

	assign adv      = !fv_q[6] || !q_full;
	assign in_stall = !adv;
	assign push     = fv_q[6] && !q_full;
	assign push_job = job_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q <= '0;
		end else if (adv) begin
			fv_q <= {fv_q[5:0], in_valid};
		end
	end

	always_comb begin
		if (cn_s6) begin
			xs = {1'b0, h2_s6} + {1'b0, ac_s6};
		end else begin
			xs = {1'b0, h2_s6} - {1'b0, ac_s6};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= DIF_W'(fin[i]) - DIF_W'(st[i]);
				oc_s1[i] <= DIF_W'(st[i]) - DIF_W'(cen[i]);
				dd_s2[i] <= d_s1[i] * d_s1[i];
				od_s2[i] <= oc_s1[i] * d_s1[i];
				oo_s2[i] <= oc_s1[i] * oc_s1[i];
			end
			r_s1  <= sphere_radius;
			rr_s2 <= r_s1 * r_s1;

			a_s3 <= A_W'(H_W'(dd_s2[0]) + H_W'(dd_s2[1]) + H_W'(dd_s2[2]));
			h_s3 <= H_W'(od_s2[0]) + H_W'(od_s2[1]) + H_W'(od_s2[2]);
			c_s3 <= H_W'(oo_s2[0]) + H_W'(oo_s2[1]) + H_W'(oo_s2[2])
				- H_W'($signed({1'b0, rr_s2}));

			a_s4  <= a_s3;
			h_s4  <= h_s3;
			hm_s4 <= h_s3[H_W-1] ? A_W'(-h_s3) : A_W'(h_s3);
			cm_s4 <= c_s3[H_W-1] ? A_W'(-c_s3) : A_W'(c_s3);
			cn_s4 <= c_s3[H_W-1];

			a_s5   <= a_s4;
			h_s5   <= h_s4;
			cn_s5  <= cn_s4;
			hll_s5 <= hm_s4[HALF_W-1:0] * hm_s4[HALF_W-1:0];
			hlh_s5 <= hm_s4[HALF_W-1:0] * hm_s4[A_W-1:HALF_W];
			hhh_s5 <= hm_s4[A_W-1:HALF_W] * hm_s4[A_W-1:HALF_W];
			all_s5 <= a_s4[HALF_W-1:0] * cm_s4[HALF_W-1:0];
			alh_s5 <= a_s4[HALF_W-1:0] * cm_s4[A_W-1:HALF_W];
			ahl_s5 <= a_s4[A_W-1:HALF_W] * cm_s4[HALF_W-1:0];
			ahh_s5 <= a_s4[A_W-1:HALF_W] * cm_s4[A_W-1:HALF_W];

			a_s6  <= a_s5;
			h_s6  <= h_s5;
			cn_s6 <= cn_s5;
			h2_s6 <= (SQ_W'(hhh_s5) << (2 * HALF_W)) + (SQ_W'(hlh_s5) << (HALF_W + 1))
				+ SQ_W'(hll_s5);
			ac_s6 <= (SQ_W'(ahh_s5) << (2 * HALF_W))
				+ ((SQ_W'(alh_s5) + SQ_W'(ahl_s5)) << HALF_W) + SQ_W'(all_s5);

			job_s7.tag.miss <= (a_s6 == '0) || xs[XS_W-1];
			job_s7.tag.a    <= a_s6;
			job_s7.tag.h    <= h_s6;
			job_s7.x        <= xs[X_W-1:0];
		end
	end

endmodule

@@ rtl/rsi_queue.sv @@
// ----------------------------------------------------------------------------
// rsi_queue
// Short queue of classified items between the front and back pipelines.
// ----------------------------------------------------------------------------
module rsi_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rsi_pkg::rsi_job_t push_job,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output rsi_pkg::rsi_job_t head_job
);
	import rsi_pkg::*;

	rsi_job_t            mem_q [QUE_D];
	logic [QUE_PW-1:0]   wr_q;
	logic [QUE_PW-1:0]   rd_q;
	logic [QUE_PW:0]     cnt_q;

	assign full       = (cnt_q == (QUE_PW+1)'(QUE_D));
	assign head_valid = (cnt_q != '0);
	assign head_job   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

endmodule

@@ rtl/rsi_back.sv @@
// ----------------------------------------------------------------------------
// rsi_back
// Pipelined square root, root numerator, divide and saturation to Q16.16.
// ----------------------------------------------------------------------------
module rsi_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             job_valid,
	input  rsi_pkg::rsi_job_t                job,
	output logic                             take,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             hit,
	output logic signed [rsi_pkg::Q_W-1:0]   hit_distance
);
	import rsi_pkg::*;

	localparam int BT = S_W + Q_W + 5;

	logic [BT-1:0] vb_q;
	logic          adv;

	logic [RD_W-1:0] rad_q [0:S_W];
	logic [S_W-1:0]  rt_q  [0:S_W];
	logic [RM_W-1:0] rm_q  [0:S_W];
	rsi_tag_t        tg_q  [0:S_W];

	logic signed [N_W-1:0] n_q;
	logic [A_W-1:0]        an_q;
	logic                  mn_q;
	logic [N_W-1:0]        mg_q;
	logic                  ng_q;
	logic [A_W-1:0]        am_q;
	logic                  mm_q;

	logic [DV_W-1:0] rmd_q [0:Q_W];
	logic [Q_W-1:0]  qd_q  [0:Q_W];
	logic [A_W-1:0]  ad_q  [0:Q_W];
	logic            md_q  [0:Q_W];
	logic            nd_q  [0:Q_W];
	logic            bd_q  [0:Q_W];

	logic [Q_W:0]   qc;
	logic [Q_W-1:0] dist_d;
	logic           hit_q;
	logic [Q_W-1:0] dist_q;

	assign adv          = !(vb_q[BT-1] && out_stall);
	assign take         = job_valid && adv;
	assign out_valid    = vb_q[BT-1];
	assign hit          = hit_q;
	assign hit_distance = dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vb_q <= '0;
		end else if (adv) begin
			vb_q <= {vb_q[BT-2:0], take};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_q[0] <= RD_W'(job.x) << (2 * COORD_FRAC_BITS);
			rt_q[0]  <= '0;
			rm_q[0]  <= '0;
			tg_q[0]  <= job.tag;
		end
	end

	for (genvar k = 1; k <= S_W; k++) begin : g_sqrt
		logic [RM_W-1:0] rmx;
		logic [RM_W-1:0] trial;
		logic            ge;

		assign rmx   = {rm_q[k-1][RM_W-3:0], rad_q[k-1][RD_W-1 -: 2]};
		assign trial = {rt_q[k-1], 2'b01};
		assign ge    = (rmx >= trial);

		always_ff @(posedge clk) begin
			if (adv) begin
				rad_q[k] <= rad_q[k-1] << 2;
				rt_q[k]  <= {rt_q[k-1][S_W-2:0], ge};
				rm_q[k]  <= ge ? rmx - trial : rmx;
				tg_q[k]  <= tg_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_q  <= N_W'(0) - (N_W'($signed(tg_q[S_W].h)) <<< COORD_FRAC_BITS)
				- N_W'({1'b0, rt_q[S_W]});
			an_q <= tg_q[S_W].a;
			mn_q <= tg_q[S_W].miss;

			ng_q <= n_q[N_W-1];
			mg_q <= n_q[N_W-1] ? N_W'(-n_q) : N_W'(n_q);
			am_q <= an_q;
			mm_q <= mn_q;

			rmd_q[0] <= DV_W'(mg_q);
			qd_q[0]  <= '0;
			ad_q[0]  <= am_q;
			md_q[0]  <= mm_q;
			nd_q[0]  <= ng_q;
			bd_q[0]  <= (DV_W'(mg_q) >= (DV_W'(am_q) << Q_W));
		end
	end

	for (genvar j = 1; j <= Q_W; j++) begin : g_div
		logic [DV_W-1:0] dsh;
		logic            dge;

		assign dsh = DV_W'(ad_q[j-1]) << (Q_W - j);
		assign dge = (rmd_q[j-1] >= dsh);

		always_ff @(posedge clk) begin
			if (adv) begin
				rmd_q[j] <= dge ? rmd_q[j-1] - dsh : rmd_q[j-1];
				qd_q[j]  <= {qd_q[j-1][Q_W-2:0], dge};
				ad_q[j]  <= ad_q[j-1];
				md_q[j]  <= md_q[j-1];
				nd_q[j]  <= nd_q[j-1];
				bd_q[j]  <= bd_q[j-1];
			end
		end
	end

	always_comb begin
		qc = {1'b0, qd_q[Q_W]} + (Q_W+1)'(rmd_q[Q_W] != '0);
		if (nd_q[Q_W]) begin
			if (bd_q[Q_W] || (qc > (Q_W+1)'(DIST_MIN))) begin
				dist_d = DIST_MIN;
			end else begin
				dist_d = Q_W'((Q_W+1)'(0) - qc);
			end
		end else begin
			if (bd_q[Q_W] || qd_q[Q_W][Q_W-1]) begin
				dist_d = DIST_MAX;
			end else begin
				dist_d = qd_q[Q_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q  <= !md_q[Q_W];
			dist_q <= md_q[Q_W] ? '0 : dist_d;
		end
	end

endmodule

@@ rtl/ray_sphere_intersection.sv @@
// ----------------------------------------------------------------------------
// ray_sphere_intersection
// Nearer intersection of a ray line with a sphere, Q16.16 in and out.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_stall  | center_*, sphere_radius, ray_start_*, ray_end_*
//  out     | out_valid / out_stall| hit, hit_distance
//
//  One item per cycle while out_stall is low; the front and back pipelines each take one.
//  Most of the back pipeline is the one-bit-per-stage square root and the
//  32-stage restoring divide.
//  Reset clears valid bits and the queue; payload registers are not reset.
//  out_stall freezes the back pipeline; the four-entry queue absorbs the front.
// ----------------------------------------------------------------------------
module ray_sphere_intersection (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [rsi_pkg::CRD_W-1:0]  center_x,
	input  logic signed [rsi_pkg::CRD_W-1:0]  center_y,
	input  logic signed [rsi_pkg::CRD_W-1:0]  center_z,
	input  logic        [rsi_pkg::RAD_W-1:0]  sphere_radius,
	input  logic signed [rsi_pkg::CRD_W-1:0]  ray_start_x,
	input  logic signed [rsi_pkg::CRD_W-1:0]  ray_start_y,
	input  logic signed [rsi_pkg::CRD_W-1:0]  ray_start_z,
	input  logic signed [rsi_pkg::CRD_W-1:0]  ray_end_x,
	input  logic signed [rsi_pkg::CRD_W-1:0]  ray_end_y,
	input  logic signed [rsi_pkg::CRD_W-1:0]  ray_end_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic signed [rsi_pkg::Q_W-1:0]    hit_distance
);
	import rsi_pkg::*;

	logic     push;
	logic     q_full;
	logic     pop;
	logic     head_valid;
	rsi_job_t push_job;
	rsi_job_t head_job;

	rsi_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.center_x      (center_x),
		.center_y      (center_y),
		.center_z      (center_z),
		.sphere_radius (sphere_radius),
		.ray_start_x   (ray_start_x),
		.ray_start_y   (ray_start_y),
		.ray_start_z   (ray_start_z),
		.ray_end_x     (ray_end_x),
		.ray_end_y     (ray_end_y),
		.ray_end_z     (ray_end_z),
		.q_full        (q_full),
		.push          (push),
		.push_job      (push_job)
	);

	rsi_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	rsi_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (head_valid),
		.job          (head_job),
		.take         (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.hit_distance (hit_distance)
	);

endmodule

@@ rtl/rsi_checker.sv @@
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks on the intersection unit, bound to the top level.
// ----------------------------------------------------------------------------
module rsi_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic signed [rsi_pkg::CRD_W-1:0]  center_x,
	input logic signed [rsi_pkg::CRD_W-1:0]  center_y,
	input logic signed [rsi_pkg::CRD_W-1:0]  center_z,
	input logic        [rsi_pkg::RAD_W-1:0]  sphere_radius,
	input logic signed [rsi_pkg::CRD_W-1:0]  ray_start_x,
	input logic signed [rsi_pkg::CRD_W-1:0]  ray_start_y,
	input logic signed [rsi_pkg::CRD_W-1:0]  ray_start_z,
	input logic signed [rsi_pkg::CRD_W-1:0]  ray_end_x,
	input logic signed [rsi_pkg::CRD_W-1:0]  ray_end_y,
	input logic signed [rsi_pkg::CRD_W-1:0]  ray_end_z,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic                              hit,
	input logic signed [rsi_pkg::Q_W-1:0]    hit_distance
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(center_x) && $stable(center_y)
			&& $stable(center_z) && $stable(sphere_radius)
			&& $stable(ray_start_x) && $stable(ray_start_y) && $stable(ray_start_z)
			&& $stable(ray_end_x) && $stable(ray_end_y) && $stable(ray_end_z))
		else $error("input item changed while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(hit_distance))
		else $error("result changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> hit_distance == '0)
		else $error("miss with nonzero distance");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result shown during reset");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result right after reset");

endmodule

bind ray_sphere_intersection rsi_checker u_rsi_checker (.*);
